// ===== design/sqve_pkg.sv =====
// types, constants and sine helpers for the sprite quad vertex expander
package sqve_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DRAW   = 2'd0;
    localparam kind_t KIND_DROP   = 2'd1;
    localparam kind_t KIND_REPORT = 2'd2;

    localparam logic ACTION_END = 1'b1;

    localparam int IN_BYTES  = 22;
    localparam int OUT_BYTES = 17;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  rgba;
        logic [31:0]  pos_x;
        logic [31:0]  pos_y;
        logic [13:0]  quads;
        logic [15:0]  indices;
    } meta_t;

    // quarter-wave sine, q1.15, 17 points
    function automatic logic [15:0] quarter_sine(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    // interpolated sine of a binary angle, q1.15 signed
    function automatic logic signed [16:0] sine_of(input logic [15:0] a);
        logic [14:0] p;
        logic [4:0]  i;
        logic [9:0]  f;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [25:0] prod;
        logic [15:0] mag;
        p = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i = p[14:10];
        f = p[9:0];
        lo = quarter_sine(i);
        hi = quarter_sine(5'(i + 5'd1));
        prod = ({10'd0, 16'(hi - lo)} * {16'd0, f}) + 26'd512;
        if (i >= 5'd16)
        begin
            mag = 16'd32768;
        end
        else
        begin
            mag = lo + 16'(prod >> 10);
        end
        return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // round a sum by 2^-32, half toward plus infinity, optionally negated first
    function automatic logic signed [17:0] round_q(input logic signed [49:0] v,
                                                   input logic neg);
        logic signed [50:0] t;
        t = neg ? (51'sd2147483648 - 51'(v)) : (51'(v) + 51'sd2147483648);
        return 18'(t >>> 32);
    endfunction

endpackage

// ===== design/sprite_quad_vertex_expander.sv =====
// sprite quad expander: rotated, scaled quad corners from draw requests
// path: pipeline stages, then corner expansion, then the output register
// flow: a draw holds corner expansion for four vertices, one per cycle while the output
//   is free, an end or drop for one; requests enter every cycle while the pipe has room
// reset: clears all valid bits and the quad count; payload registers are not reset
module sprite_quad_vertex_expander
    import sqve_pkg::*;
#(
    parameter int MAX_QUADS = 8192
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pos_x, pos_y, size_x, size_y, angle, rgba
    input  logic [IN_BYTES*8-1:0]    s_tdata,
    // action
    input  logic [0:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // vertex_x, vertex_y, tex_u, tex_v, vertex_rgba, corner, quads_done, indices_done, pad
    output logic [OUT_BYTES*8-1:0]   m_tdata,
    // batch_report, overflow
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int QW = $clog2(MAX_QUADS + 1);

    // quad count
    logic [QW-1:0] quad_total_reg;
    logic [QW-1:0] quad_total_next;
    logic [QW-1:0] cnt_view;
    logic [31:0]   cnt32;
    logic [31:0]   idx32;
    kind_t         kind_in;
    logic          acc;
    meta_t         meta_in;

    // pipeline stages
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t                m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0]   sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic [15:0]          ang1_reg;
    logic signed [16:0]   sin2_reg, cos2_reg;
    logic signed [48:0]   p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [49:0]   a4_reg, b4_reg, c4_reg, d4_reg;

    // corner expansion stage
    logic                 e_valid_reg;
    logic [1:0]           e_corner_reg;
    meta_t                e_meta_reg;
    logic signed [17:0]   e_x_reg [4];
    logic signed [17:0]   e_y_reg [4];

    // output register
    logic                     m_tvalid_reg;
    logic [OUT_BYTES*8-1:0]   m_tdata_reg;
    logic [1:0]               m_tuser_reg;
    logic                     m_tlast_reg;
    logic [OUT_BYTES*8-1:0]   tdata_next;
    logic [1:0]               tuser_next;
    logic                     tlast_next;
    logic [31:0]              vx_next;
    logic [31:0]              vy_next;

    logic o_free, emit, e_last, e_done, e_take;
    logic take4, take3, take2, take1;

    // flow control
    assign o_free = !m_tvalid_reg || m_tready;
    assign emit   = e_valid_reg && o_free;
    assign e_last = (e_meta_reg.kind != KIND_DRAW) || (e_corner_reg == 2'd3);
    assign e_done = emit && e_last;
    assign e_take = !e_valid_reg || e_done;
    assign take4  = !v4_reg || e_take;
    assign take3  = !v3_reg || take4;
    assign take2  = !v2_reg || take3;
    assign take1  = !v1_reg || take2;
    assign s_tready = take1;
    assign acc = s_tvalid && s_tready;

    // request classification and count snapshot
    always_comb
    begin
        if (s_tuser[0] == ACTION_END)
        begin
            kind_in = KIND_REPORT;
        end
        else if (quad_total_reg >= QW'(MAX_QUADS))
        begin
            kind_in = KIND_DROP;
        end
        else
        begin
            kind_in = KIND_DRAW;
        end
        cnt_view = (kind_in == KIND_DRAW) ? QW'(quad_total_reg + 1'b1) : quad_total_reg;
        cnt32 = 32'(cnt_view);
        idx32 = cnt32 * 32'd6;
        quad_total_next = quad_total_reg;
        if (acc)
        begin
            quad_total_next = (kind_in == KIND_REPORT) ? '0 : cnt_view;
        end
        meta_in.kind    = kind_in;
        meta_in.rgba    = s_tdata[175:144];
        meta_in.pos_x   = s_tdata[31:0];
        meta_in.pos_y   = s_tdata[63:32];
        meta_in.quads   = cnt32[13:0];
        meta_in.indices = idx32[15:0];
    end

    // vertex for the current corner
    always_comb
    begin
        vx_next = e_meta_reg.pos_x + 32'(e_x_reg[e_corner_reg]);
        vy_next = e_meta_reg.pos_y + 32'(e_y_reg[e_corner_reg]);
        tdata_next = '0;
        tdata_next[113:100] = e_meta_reg.quads;
        tdata_next[129:114] = e_meta_reg.indices;
        tuser_next = {e_meta_reg.kind == KIND_DROP, e_meta_reg.kind == KIND_REPORT};
        tlast_next = e_last;
        if (e_meta_reg.kind == KIND_DRAW)
        begin
            tdata_next[31:0]  = vx_next;
            tdata_next[63:32] = vy_next;
            tdata_next[64]    = e_corner_reg[0] ^ e_corner_reg[1];
            tdata_next[65]    = e_corner_reg[1];
            tdata_next[97:66] = e_meta_reg.rgba;
            tdata_next[99:98] = e_corner_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_total_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            e_valid_reg    <= 1'b0;
            e_corner_reg   <= 2'd0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            quad_total_reg <= quad_total_next;
            if (take1)
            begin
                v1_reg <= s_tvalid;
            end
            if (take2)
            begin
                v2_reg <= v1_reg;
            end
            if (take3)
            begin
                v3_reg <= v2_reg;
            end
            if (take4)
            begin
                v4_reg <= v3_reg;
            end
            if (e_take)
            begin
                e_valid_reg  <= v4_reg;
                e_corner_reg <= 2'd0;
            end
            else if (emit)
            begin
                e_corner_reg <= e_corner_reg + 2'd1;
            end
            if (o_free)
            begin
                m_tvalid_reg <= e_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            m1_reg   <= meta_in;
            sx1_reg  <= s_tdata[95:64];
            sy1_reg  <= s_tdata[127:96];
            ang1_reg <= s_tdata[143:128];
        end
        if (take2)
        begin
            m2_reg   <= m1_reg;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            sin2_reg <= sine_of(ang1_reg);
            cos2_reg <= sine_of(ang1_reg + 16'd16384);
        end
        if (take3)
        begin
            m3_reg <= m2_reg;
            p1_reg <= sx2_reg * cos2_reg;
            p2_reg <= sy2_reg * sin2_reg;
            p3_reg <= sx2_reg * sin2_reg;
            p4_reg <= sy2_reg * cos2_reg;
        end
        if (take4)
        begin
            m4_reg <= m3_reg;
            a4_reg <= 50'(p1_reg) + 50'(p2_reg);
            b4_reg <= 50'(p1_reg) - 50'(p2_reg);
            c4_reg <= 50'(p3_reg) + 50'(p4_reg);
            d4_reg <= 50'(p3_reg) - 50'(p4_reg);
        end
        if (e_take)
        begin
            e_meta_reg <= m4_reg;
            e_x_reg[0] <= round_q(b4_reg, 1'b1);
            e_x_reg[1] <= round_q(a4_reg, 1'b0);
            e_x_reg[2] <= round_q(b4_reg, 1'b0);
            e_x_reg[3] <= round_q(a4_reg, 1'b1);
            e_y_reg[0] <= round_q(c4_reg, 1'b1);
            e_y_reg[1] <= round_q(d4_reg, 1'b0);
            e_y_reg[2] <= round_q(c4_reg, 1'b0);
            e_y_reg[3] <= round_q(d4_reg, 1'b1);
        end
        if (o_free)
        begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
            m_tlast_reg <= tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_draw_last_on_corner3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == 2'b00) |-> (m_tlast == (m_tdata[99:98] == 2'd3)))
        else $error("draw vertex last flag does not match corner");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 2'b00) |-> m_tlast && (m_tdata[99:98] == 2'd0)
            && (m_tuser != 2'b11))
        else $error("report or drop result malformed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        quad_total_reg <= QW'(MAX_QUADS))
        else $error("quad count above capacity");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == ACTION_END) |=> (quad_total_reg == '0))
        else $error("end request did not clear the quad count");

    a_corner_moves_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && !o_free |=> $stable(e_corner_reg))
        else $error("corner advanced while output was blocked");

endmodule

// ===== sim/sprite_quad_vertex_expander_tb.sv =====
// testbench for the sprite quad vertex expander: random and directed draw and end requests
`timescale 1ns / 100ps

typedef struct packed {
    logic        action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [15:0] angle;
    logic [31:0] rgba;
} request_t;

typedef struct packed {
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic        tex_u;
    logic        tex_v;
    logic [31:0] rgba;
    logic [1:0]  corner;
    logic        last;
    logic        batch_report;
    logic [13:0] quads_done;
    logic [15:0] indices_done;
    logic        overflow;
} result_item_t;

localparam logic ACTION_DRAW = 1'b0;
localparam longint ROUND_HALF = 64'sd2147483648;
localparam int QUARTER_SINE [17] = '{
    0, 3212, 6393, 9512, 12540, 15447, 18205, 20788,
    23170, 25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768
};

class vertex_scoreboard;
    int unsigned  quad_limit;
    int unsigned  quad_total;
    int unsigned  errors;
    result_item_t expected_q[$];

    function new(int unsigned limit);
        quad_limit = limit;
        quad_total = 0;
        errors     = 0;
    endfunction

    function int sine_q15(logic [15:0] a);
        int p;
        int i;
        int f;
        int mag;
        p = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
        i = p >> 10;
        f = p & 1023;
        if (i >= 16)
        begin
            mag = QUARTER_SINE[16];
        end
        else
        begin
            mag = QUARTER_SINE[i]
                + (((QUARTER_SINE[i + 1] - QUARTER_SINE[i]) * f + 512) >> 10);
        end
        return a[15] ? -mag : mag;
    endfunction

    function void note_request(request_t r);
        result_item_t v;
        longint       c;
        longint       s;
        longint       szx;
        longint       szy;
        longint       sx;
        longint       sy;
        longint       sum_x;
        longint       sum_y;
        v = '0;
        if (r.action == sqve_pkg::ACTION_END)
        begin
            v.last         = 1'b1;
            v.batch_report = 1'b1;
            v.quads_done   = 14'(quad_total);
            v.indices_done = 16'(quad_total * 6);
            expected_q.push_back(v);
            quad_total = 0;
        end
        else if (quad_total >= quad_limit)
        begin
            v.last         = 1'b1;
            v.overflow     = 1'b1;
            v.quads_done   = 14'(quad_total);
            v.indices_done = 16'(quad_total * 6);
            expected_q.push_back(v);
        end
        else
        begin
            s   = sine_q15(r.angle);
            c   = sine_q15(r.angle + 16'h4000);
            szx = $signed(r.size_x);
            szy = $signed(r.size_y);
            quad_total++;
            for (int k = 0; k < 4; k++)
            begin
                sx    = (k == 0 || k == 3) ? -szx : szx;
                sy    = (k < 2) ? -szy : szy;
                sum_x = sx * c - sy * s;
                sum_y = sx * s + sy * c;
                v = '0;
                v.vertex_x     = 32'((sum_x + ROUND_HALF) >>> 32) + r.pos_x;
                v.vertex_y     = 32'((sum_y + ROUND_HALF) >>> 32) + r.pos_y;
                v.tex_u        = (k == 1 || k == 2);
                v.tex_v        = (k >= 2);
                v.rgba         = r.rgba;
                v.corner       = 2'(k);
                v.last         = (k == 3);
                v.quads_done   = 14'(quad_total);
                v.indices_done = 16'(quad_total * 6);
                expected_q.push_back(v);
            end
        end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endfunction

    function void check_vertex(result_item_t got);
        result_item_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: result expected none got %0h", $time, got);
        end
        else
        begin
            want = expected_q.pop_front();
            compare("vertex_x", want.vertex_x, got.vertex_x);
            compare("vertex_y", want.vertex_y, got.vertex_y);
            compare("tex_u", want.tex_u, got.tex_u);
            compare("tex_v", want.tex_v, got.tex_v);
            compare("vertex_rgba", want.rgba, got.rgba);
            compare("corner", want.corner, got.corner);
            compare("last", want.last, got.last);
            compare("batch_report", want.batch_report, got.batch_report);
            compare("quads_done", want.quads_done, got.quads_done);
            compare("indices_done", want.indices_done, got.indices_done);
            compare("overflow", want.overflow, got.overflow);
        end
    endfunction
endclass

module sprite_quad_vertex_expander_tb;
    import sqve_pkg::*;

    localparam int QUAD_LIMIT     = 8192;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BYTES*8-1:0]    s_tdata = '0;
    logic [0:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0]   m_tdata;
    logic [1:0]               m_tuser;
    logic                     m_tlast;

    bit                       idle_on = 1'b1;
    int                       quiet_cycles = 0;
    vertex_scoreboard         book = new(QUAD_LIMIT);

    sprite_quad_vertex_expander #(
        .MAX_QUADS (QUAD_LIMIT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check and random stall
    always @(posedge clk)
    begin
        result_item_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.vertex_x     = m_tdata[31:0];
                got.vertex_y     = m_tdata[63:32];
                got.tex_u        = m_tdata[64];
                got.tex_v        = m_tdata[65];
                got.rgba         = m_tdata[97:66];
                got.corner       = m_tdata[99:98];
                got.quads_done   = m_tdata[113:100];
                got.indices_done = m_tdata[129:114];
                got.last         = m_tlast;
                got.batch_report = m_tuser[0];
                got.overflow     = m_tuser[1];
                book.check_vertex(got);
            end
            m_tready <= !(idle_on && $urandom_range(0, 99) < 6);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sprite_quad_vertex_expander_tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input request_t r);
        if (idle_on && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {r.rgba, r.angle, r.size_y, r.size_x, r.pos_y, r.pos_x};
        do @(posedge clk); while (!s_tready);
        book.note_request(r);
    endtask

    task automatic draw(input logic [31:0] px, input logic [31:0] py,
                        input logic [31:0] szx, input logic [31:0] szy,
                        input logic [15:0] a, input logic [31:0] color);
        send_request('{ACTION_DRAW, px, py, szx, szy, a, color});
    endtask

    task automatic end_batch(input logic [31:0] filler);
        send_request('{ACTION_END, filler, filler, filler, filler, filler[15:0], filler});
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 3))
            0: pick_word = {{12{w[31]}}, w[19:0]};
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       pick_word = 32'h7FFF_FFFF;
                    1:       pick_word = 32'h8000_0000;
                    2:       pick_word = 32'h0000_0000;
                    3:       pick_word = 32'hFFFF_FFFF;
                    default: pick_word = 32'h0001_0000;
                endcase
            end
            default: pick_word = w;
        endcase
    endfunction

    task automatic random_request(input int end_pct);
        request_t r;
        r.action = ($urandom_range(0, 99) < end_pct) ? ACTION_END : ACTION_DRAW;
        r.pos_x  = pick_word();
        r.pos_y  = pick_word();
        r.size_x = pick_word();
        r.size_y = pick_word();
        r.angle  = ($urandom_range(0, 3) == 0) ? 16'({$urandom_range(0, 3), 14'd0})
                                               : 16'($urandom_range(0, 65535));
        r.rgba   = $urandom;
        send_request(r);
    endtask

    // hold requests until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain, quadrant edges, extreme sizes and positions
        draw(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h0000, 32'hFFFF_FFFF);
        draw(32'h0005_0000, 32'hFFFB_0000, 32'h0020_0000, 32'h0010_0000, 16'h4000,
             32'h1122_3344);
        draw(32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 32'h0001_0000, 16'h8000,
             32'hA5A5_A5A5);
        draw(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0004_0000, 16'hC000,
             32'h5A5A_5A5A);
        draw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
             32'h0000_0000);
        draw(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h2000,
             32'hFFFF_FFFF);
        draw(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001,
             32'h0F0F_0F0F);
        draw(32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 32'h0000_0000, 16'h3FFF,
             32'h0000_0000);
        draw(32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h6000,
             32'hF0F0_F0F0);
        draw(32'h7FFF_0000, 32'h8000_FFFF, 32'h0100_0000, 32'h00FF_0000, 16'h4001,
             32'h8000_0001);
        end_batch(32'h0);
        end_batch(32'h0);
        end_batch(32'hFFFF_FFFF);
        draw(32'h0000_1234, 32'hFFFF_EDCB, 32'h0002_0000, 32'hFFFE_0000, 16'hBFFF,
             32'hDEAD_BEEF);
        draw(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234,
             32'h0123_4567);
        draw(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h8001, 32'hFFFF_FFFF);
        end_batch(32'h0);
        drain_results();

        // random draws and ends, with a stretch of no idling
        for (int n = 0; n < 100; n++)
        begin
            idle_on = !(n >= 35 && n < 70);
            random_request(10);
        end
        idle_on = 1'b1;
        end_batch($urandom);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.expected_q.size() == 0)
            $display("sprite_quad_vertex_expander_tb: PASS");
        else
            $display("sprite_quad_vertex_expander_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sqve_pkg.sv
design/sprite_quad_vertex_expander.sv
sim/sprite_quad_vertex_expander_tb.sv
